// ===== hw/rtl/fsr_force_predictive_filter_defines.svh =====
// Assertion helpers; expect clock and reset in the using scope.
`ifndef FSR_FORCE_PREDICTIVE_FILTER_DEFINES_SVH
`define FSR_FORCE_PREDICTIVE_FILTER_DEFINES_SVH

// Same-cycle implication.
`define FSR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsr same-cycle check failed");

// Next-cycle implication.
`define FSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsr next-cycle check failed");

`endif

// ===== hw/rtl/fsr_pkg.sv =====
package fsr_pkg;

   localparam int SAMPLE_BITS     = 10;
   localparam int FORCE_FRAC_BITS = 8;
   localparam int FORCE_BITS      = 40;

   localparam int GAIN_W     = 17;
   localparam int GAIN_FRAC  = 16;
   localparam int RES_W      = 20;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_GAIN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES_RES = CSR_IDX_W'(2);

   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32768);
   localparam logic [RES_W-1:0]  RES_RESET  = RES_W'(10000);

   // 13e6 * 2^frac: the 200 and 0.6/0.003 factors cancel out of the model
   localparam logic [63:0] MODEL_K   = 64'd13000000 << FORCE_FRAC_BITS;
   localparam int          MODEL_K_W = $clog2(MODEL_K + 64'd1);

   localparam int NUM_W     = MODEL_K_W + SAMPLE_BITS;
   localparam int RES_X3_W  = RES_W + 2;
   localparam int DEN_W     = RES_X3_W + SAMPLE_BITS;
   localparam int PRED_W    = FORCE_BITS + 2;
   localparam int MUL_A_W   = FORCE_BITS + 3;
   localparam int MUL_B_W   = GAIN_W;
   localparam int ACC_W     = MUL_A_W + MUL_B_W;
   localparam int BQ_W      = ACC_W - GAIN_FRAC;
   localparam int QX_W      = (NUM_W > FORCE_BITS) ? NUM_W : FORCE_BITS;

   localparam int MUL_DIGITS = (MUL_B_W + 1) / 2;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

   localparam logic signed [FORCE_BITS-1:0] FORCE_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
   localparam logic signed [FORCE_BITS-1:0] FORCE_MIN = {1'b1, {(FORCE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_MODEL,
      ST_DIVIDE,
      ST_BLEND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== hw/rtl/fsr_req_if.sv =====
interface fsr_req_if;
   import fsr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== hw/rtl/fsr_rsp_if.sv =====
interface fsr_rsp_if;
   import fsr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [FORCE_BITS-1:0] force_estimate;
   logic                         saturated;

   modport source (output valid, output force_estimate, output saturated, input ready);
   modport sink (input valid, input force_estimate, input saturated, output ready);
endinterface

// ===== hw/rtl/fsr_serial_mul.sv =====
// Radix-4 shift-add multiplier: two multiplier bits per cycle, signed
// multiplicand, unsigned multiplier, accumulator preloaded with an offset.
module fsr_serial_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [fsr_pkg::MUL_A_W-1:0]   mcand,
   input  logic        [fsr_pkg::MUL_B_W-1:0]   mplier,
   input  logic signed [fsr_pkg::ACC_W-1:0]     acc_init,
   output logic signed [fsr_pkg::ACC_W-1:0]     product,
   output fsr_pkg::unit_stat_type               stat
);
   import fsr_pkg::*;

   localparam int PL_W = 2 * MUL_DIGITS;

   logic signed [ACC_W-1:0] mcand_ext;
   logic signed [ACC_W-1:0] addend;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic signed [ACC_W-1:0] mcand3_ff, mcand3_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [PL_W-1:0]         mplier_ff, mplier_in;
   logic [MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   assign mcand_ext = ACC_W'(mcand);

   always_comb begin
      case (mplier_ff[1:0])
         2'd0:    addend = '0;
         2'd1:    addend = mcand_ff;
         2'd2:    addend = mcand_ff <<< 1;
         default: addend = mcand3_ff;
      endcase
   end

   always_comb begin
      mcand_in  = mcand_ff;
      mcand3_in = mcand3_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mcand_ext;
         mcand3_in = mcand_ext + (mcand_ext <<< 1);
         acc_in    = acc_init;
         mplier_in = PL_W'(mplier);
         cnt_in    = MUL_CNT_W'(MUL_DIGITS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + addend;
         mcand_in  = mcand_ff <<< 2;
         mcand3_in = mcand3_ff <<< 2;
         mplier_in = mplier_ff >> 2;
         cnt_in    = cnt_ff - MUL_CNT_W'(1);
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mcand3_ff <= mcand3_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/fsr_serial_div.sv =====
// Restoring divider, one quotient bit per cycle. The dividend shifts out of
// the top of the quotient register while quotient bits shift in at the bottom.
module fsr_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fsr_pkg::NUM_W-1:0]      dividend,
   input  logic [fsr_pkg::DEN_W-1:0]      divisor,
   output logic [fsr_pkg::NUM_W-1:0]      quotient,
   output fsr_pkg::unit_stat_type         stat
);
   import fsr_pkg::*;

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     trial;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow means the trial subtract failed: keep the shifted remainder
         quo_in = {quo_ff[NUM_W-2:0], ~trial[DEN_W+1]};
         rem_in = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/fsr_force_predictive_filter.sv =====
// Force estimator for a force-sensing resistor read through a divider. Each
// request carries one raw converter sample; the block low-pass filters it
// into an integer level, maps the level to a force with the resistor model
// 13e6 * (2^SAMPLE_BITS - u) / (3 * R * u) in Q.8, predicts the next force
// as 2*now - prev, and blends model and prediction with force_gain. One
// response comes back per request: a signed 40-bit force (8 fractional bits)
// and a saturated flag, set when the level or series_resistance is zero or a
// force hit the 40-bit limit. Gains above 65536 act as 65536. Each request
// runs three radix-4 multiplies (level, model numerator and denominator side
// by side, blend) and a bit-serial divide. Only one request is in flight;
// the response sits in an output register, so the next request is accepted
// while it waits. Configuration writes take effect at once and belong only
// to idle periods.
`include "fsr_force_predictive_filter_defines.svh"

module fsr_force_predictive_filter (
   input  logic                               clock,
   input  logic                               reset,
   fsr_req_if.sink                            req_if,
   fsr_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsr_pkg::*;

   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

   // control
   state_type state_ff, state_in;
   logic      req_fire;
   logic      out_free;
   logic      units_idle;

   // configuration registers
   logic [GAIN_W-1:0] level_gain_ff, level_gain_in;
   logic [GAIN_W-1:0] force_gain_ff, force_gain_in;
   logic [RES_W-1:0]  series_res_ff, series_res_in;

   // filter state
   logic [SAMPLE_BITS-1:0]       level_ff, level_in;
   logic signed [FORCE_BITS-1:0] force_now_ff, force_now_in;
   logic signed [FORCE_BITS-1:0] force_prev_ff, force_prev_in;
   logic signed [PRED_W-1:0]     pred_ff, pred_in;
   logic                         sat_ff, sat_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [FORCE_BITS-1:0] rsp_force_ff, rsp_force_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   // shared multiplier A: level, model numerator, blend
   logic                        mul_a_start;
   logic signed [MUL_A_W-1:0]   mul_a_mcand;
   logic [MUL_B_W-1:0]          mul_a_mplier;
   logic signed [ACC_W-1:0]     mul_a_init;
   logic signed [ACC_W-1:0]     product_a;
   unit_stat_type               mul_a_stat;

   // multiplier B: model denominator
   logic                        mul_b_start;
   logic signed [MUL_A_W-1:0]   mul_b_mcand;
   logic [MUL_B_W-1:0]          mul_b_mplier;
   logic signed [ACC_W-1:0]     product_b;
   unit_stat_type               mul_b_stat;

   // divider
   logic                        div_start;
   logic [NUM_W-1:0]            quotient;
   unit_stat_type               div_stat;

   // datapath terms
   logic signed [SAMPLE_BITS:0]  level_diff;
   logic [SAMPLE_BITS-1:0]       new_level;
   logic [SAMPLE_BITS:0]         span_left;
   logic [RES_X3_W-1:0]          series_x3;
   logic signed [PRED_W-1:0]     pred_next;
   logic [QX_W-1:0]              quo_ext;
   logic                         model_clamp;
   logic signed [FORCE_BITS-1:0] model_val;
   logic signed [MUL_A_W-1:0]    blend_diff;
   logic                         blend_round;
   logic [BQ_W-1:0]              blend_q;
   logic                         blend_pos_ovf;
   logic                         blend_neg_ovf;
   logic signed [FORCE_BITS-1:0] blend_val;

   assign req_fire   = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign units_idle = !mul_a_stat.busy && !mul_b_stat.busy && !div_stat.busy;

   // level step: L + ((g * (s - L)) >>> 16), run as (L << 16) + g * (s - L)
   assign level_diff = {1'b0, req_if.adc_sample} - {1'b0, level_ff};

   // new level is valid while multiplier A reports done in the level phase
   assign new_level = product_a[GAIN_FRAC +: SAMPLE_BITS];
   assign span_left = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, new_level};
   assign series_x3 = RES_X3_W'(series_res_ff) + (RES_X3_W'(series_res_ff) << 1);

   assign mul_b_mcand  = MUL_A_W'(series_x3);
   assign mul_b_mplier = MUL_B_W'(new_level);

   assign pred_next = (PRED_W'(force_now_ff) <<< 1) - PRED_W'(force_prev_ff);

   // model force: zero level, zero resistor or a quotient past the force range pins it at full scale
   assign quo_ext     = QX_W'(quotient);
   assign model_clamp = (level_ff == '0) || (series_res_ff == '0) ||
                        (|quo_ext[QX_W-1:FORCE_BITS-1]);
   assign model_val   = model_clamp ? FORCE_MAX : quo_ext[FORCE_BITS-1:0];
   assign blend_diff  = MUL_A_W'(model_val) - MUL_A_W'(pred_ff);

   // blend = (pred << 16) + h * (model - pred), divided by 2^16 toward zero
   assign blend_round   = product_a[ACC_W-1] && (|product_a[GAIN_FRAC-1:0]);
   assign blend_q       = product_a[ACC_W-1:GAIN_FRAC] + BQ_W'(blend_round);
   assign blend_pos_ovf = !blend_q[BQ_W-1] && (|blend_q[BQ_W-2:FORCE_BITS-1]);
   assign blend_neg_ovf = blend_q[BQ_W-1] && !(&blend_q[BQ_W-2:FORCE_BITS-1]);
   assign blend_val     = blend_pos_ovf ? FORCE_MAX :
                          blend_neg_ovf ? FORCE_MIN : blend_q[FORCE_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      level_gain_in = level_gain_ff;
      force_gain_in = force_gain_ff;
      series_res_in = series_res_ff;
      level_in      = level_ff;
      force_now_in  = force_now_ff;
      force_prev_in = force_prev_ff;
      pred_in       = pred_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_force_in  = rsp_force_ff;
      rsp_sat_in    = rsp_sat_ff;
      mul_a_start   = 1'b0;
      mul_a_mcand   = '0;
      mul_a_mplier  = '0;
      mul_a_init    = '0;
      mul_b_start   = 1'b0;
      div_start     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_GAIN: level_gain_in = GAIN_W'(csr_wdata);
            CSR_FORCE_GAIN: force_gain_in = GAIN_W'(csr_wdata);
            CSR_SERIES_RES: series_res_in = RES_W'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mul_a_start  = 1'b1;
               mul_a_mcand  = MUL_A_W'(level_diff);
               mul_a_mplier = clamp_gain(level_gain_ff);
               mul_a_init   = ACC_W'({level_ff, {GAIN_FRAC{1'b0}}});
               pred_in      = pred_next;
               sat_in       = 1'b0;
               state_in     = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (mul_a_stat.done) begin
               level_in     = new_level;
               // numerator and denominator of the model run side by side
               mul_a_start  = 1'b1;
               mul_a_mcand  = MUL_A_W'(MODEL_K);
               mul_a_mplier = MUL_B_W'(span_left);
               mul_b_start  = 1'b1;
               state_in     = ST_MODEL;
            end
         end
         ST_MODEL: begin
            if (mul_a_stat.done) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               sat_in       = model_clamp;
               mul_a_start  = 1'b1;
               mul_a_mcand  = blend_diff;
               mul_a_mplier = clamp_gain(force_gain_ff);
               mul_a_init   = ACC_W'(pred_ff) <<< GAIN_FRAC;
               state_in     = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (mul_a_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold here until the response register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_force_in  = blend_val;
               rsp_sat_in    = sat_ff || blend_pos_ovf || blend_neg_ovf;
               force_prev_in = force_now_ff;
               force_now_in  = blend_val;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_gain_ff <= GAIN_RESET;
         force_gain_ff <= GAIN_RESET;
         series_res_ff <= RES_RESET;
         level_ff      <= '0;
         force_now_ff  <= '0;
         force_prev_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         level_gain_ff <= level_gain_in;
         force_gain_ff <= force_gain_in;
         series_res_ff <= series_res_in;
         level_ff      <= level_in;
         force_now_ff  <= force_now_in;
         force_prev_ff <= force_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pred_ff      <= pred_in;
      sat_ff       <= sat_in;
      rsp_force_ff <= rsp_force_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   fsr_serial_mul u_mul_a (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_a_start),
      .mcand    (mul_a_mcand),
      .mplier   (mul_a_mplier),
      .acc_init (mul_a_init),
      .product  (product_a),
      .stat     (mul_a_stat)
   );

   fsr_serial_mul u_mul_b (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_b_start),
      .mcand    (mul_b_mcand),
      .mplier   (mul_b_mplier),
      .acc_init ('0),
      .product  (product_b),
      .stat     (mul_b_stat)
   );

   fsr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_a[NUM_W-1:0]),
      .divisor  (product_b[DEN_W-1:0]),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.force_estimate = rsp_force_ff;
   assign rsp_if.saturated      = rsp_sat_ff;

   // a new request never lands on a unit that is still working
   `FSR_ASSERT_SAME(a_accept_units_idle, req_fire, units_idle)
   // numerator and denominator finish in the same cycle
   `FSR_ASSERT_SAME(a_model_lockstep, (state_ff == ST_MODEL) && mul_a_stat.done, mul_b_stat.done)
   // the smoothed level only moves at the end of the level step
   `FSR_ASSERT_NEXT(a_level_hold, state_ff != ST_LEVEL, $stable(level_ff))
   // a finished request always shows up as a response
   `FSR_ASSERT_NEXT(a_rsp_loaded, (state_ff == ST_FINISH) && out_free, rsp_if.valid)

endmodule

// ===== bench/tb_fsr_force_predictive_filter.sv =====
`timescale 1ns / 100ps

// Force filter bench: the stimulus process walks a directed table of samples and
// register writes. It then runs random phases, each with its own register setting.
// A monitor on the rising edge keeps a cycle-free copy of the filter state. It
// predicts each response when the request is accepted and checks responses in order.
module tb_fsr_force_predictive_filter;
   import fsr_pkg::*;

   localparam int ITEM_TARGET = 1200;   // random requests after the directed table
   localparam int QUIET_TAIL  = 150;    // last requests run with no idling at all
   localparam int STALL_LIMIT = 2000;   // cycles without any handshake or write
   localparam int DRAIN_TAIL  = 100;    // settle time after the last response

   // index 3 decodes to nothing; writes there must not disturb anything
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam longint FORCE_HI = (longint'(1) <<< (FORCE_BITS - 1)) - 1;
   localparam longint FORCE_LO = -FORCE_HI - 1;
   localparam longint unsigned FULL_SCALE = 64'd1 << SAMPLE_BITS;
   localparam longint unsigned GAIN_UNITY = 64'd1 << GAIN_FRAC;

   typedef struct packed {
      logic signed [FORCE_BITS-1:0] force_estimate;
      logic                         saturated;
   } force_result_type;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic [CSR_IDX_W-1:0]         index;
      logic [CSR_DATA_W-1:0]        value;    // sample in the low bits for sample rows
      bit                           pinned;   // expectation typed into the row
      logic signed [FORCE_BITS-1:0] want_force;
      logic                         want_sat;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fsr_req_if req_bus();
   fsr_rsp_if rsp_bus();

   fsr_force_predictive_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Filter state as the monitor sees it, updated at accepted requests and writes.
   logic [GAIN_W-1:0]      level_gain_q;
   logic [GAIN_W-1:0]      force_gain_q;
   logic [RES_W-1:0]       series_res_q;
   logic [SAMPLE_BITS-1:0] level_q;
   longint                 force_now_q;
   longint                 force_prev_q;

   force_result_type expected_forces[$];
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   bit               idle_enable;

   // Typed expectation for the request currently offered, if any.
   bit                           pin_typed;
   logic signed [FORCE_BITS-1:0] pin_force;
   logic                         pin_sat;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // One filter step: level low-pass, resistor model, extrapolation, blend.
   function automatic force_result_type step_force_filter(input logic [SAMPLE_BITS-1:0] sample);
      longint unsigned  g, lvl, num, den, quo;
      longint           h, model, pred, acc, blend;
      force_result_type res;
      // gains saturate at unity
      g = (level_gain_q > GAIN_ONE) ? GAIN_ONE : level_gain_q;
      h = (force_gain_q > GAIN_ONE) ? GAIN_ONE : force_gain_q;
      res.saturated = 1'b0;

      lvl = (g * sample + (GAIN_UNITY - g) * level_q) >> GAIN_FRAC;
      level_q = lvl[SAMPLE_BITS-1:0];

      // zero level or zero resistor: model pinned at full force
      if (level_q == 0 || series_res_q == 0) begin
         model = FORCE_HI;
         res.saturated = 1'b1;
      end else begin
         num = MODEL_K * (FULL_SCALE - level_q);
         den = 64'd3 * series_res_q * level_q;
         quo = num / den;
         if (quo > FORCE_HI) begin
            model = FORCE_HI;
            res.saturated = 1'b1;
         end else begin
            model = longint'(quo);
         end
      end

      pred  = 2 * force_now_q - force_prev_q;
      acc   = h * model + (longint'(GAIN_UNITY) - h) * pred;
      blend = acc / longint'(GAIN_UNITY);   // truncates toward zero
      if (blend > FORCE_HI) begin
         blend = FORCE_HI;
         res.saturated = 1'b1;
      end else if (blend < FORCE_LO) begin
         blend = FORCE_LO;
         res.saturated = 1'b1;
      end

      force_prev_q = force_now_q;
      force_now_q  = blend;
      res.force_estimate = blend[FORCE_BITS-1:0];
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Monitor: register writes, request acceptance, response check, watchdog.
   always @(posedge clock) begin : monitor
      force_result_type want;
      bit               moved;
      if (reset) begin
         level_gain_q = GAIN_RESET;
         force_gain_q = GAIN_RESET;
         series_res_q = RES_RESET;
         level_q      = '0;
         force_now_q  = 0;
         force_prev_q = 0;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_we === 1'b1) begin
            moved = 1'b1;
            case (csr_index)
               CSR_LEVEL_GAIN: level_gain_q = csr_wdata[GAIN_W-1:0];
               CSR_FORCE_GAIN: force_gain_q = csr_wdata[GAIN_W-1:0];
               CSR_SERIES_RES: series_res_q = csr_wdata[RES_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            moved = 1'b1;
            want = step_force_filter(req_bus.adc_sample);
            if (pin_typed) begin
               want.force_estimate = pin_force;
               want.saturated      = pin_sat;
            end
            expected_forces.push_back(want);
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            moved = 1'b1;
            if (expected_forces.size() == 0) begin
               flag_mismatch("unexpected response", rsp_bus.force_estimate, 0);
            end else begin
               want = expected_forces.pop_front();
               if (rsp_bus.force_estimate !== want.force_estimate)
                  flag_mismatch("force_estimate", rsp_bus.force_estimate,
                                want.force_estimate);
               if (rsp_bus.saturated !== want.saturated)
                  flag_mismatch("saturated", rsp_bus.saturated, want.saturated);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_fsr_force_predictive_filter failed");
            $finish;
         end
      end
   end

   // Response side: ready drops in random bursts while idling is allowed.
   initial begin : response_sink
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 19) == 0) begin
            hold = $urandom_range(1, 14) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.adc_sample <= smp;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off new requests until every outstanding response is back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_forces.size() != 0) @(negedge clock);
   endtask

   // One-cycle write strobe; the task returns with csr_we low so strobes never merge.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic stim_row_type sample_row(input int smp);
      stim_row_type r;
      r = '{ROW_SAMPLE, CSR_LEVEL_GAIN, CSR_DATA_W'(smp), 1'b0, '0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type pinned_row(input int smp,
                                               input logic signed [FORCE_BITS-1:0] f,
                                               input logic s);
      stim_row_type r;
      r = '{ROW_SAMPLE, CSR_LEVEL_GAIN, CSR_DATA_W'(smp), 1'b1, f, s};
      return r;
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '{ROW_WRITE, idx, val, 1'b0, '0, 1'b0};
      return r;
   endfunction

   // Gain picks: zero, unity, tiny, above unity (upper data bits too), typical.
   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CSR_DATA_W'(GAIN_ONE);
         2:       return CSR_DATA_W'($urandom());
         3:       return CSR_DATA_W'($urandom_range(1, 16));
         default: return CSR_DATA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_resistance();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2:       return '1;
         3:       return CSR_DATA_W'($urandom());
         default: return CSR_DATA_W'($urandom_range(100, 200000));
      endcase
   endfunction

   initial begin : stimulus
      int                     sent;
      int                     phase_len;
      logic [SAMPLE_BITS-1:0] smp;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.adc_sample = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      idle_enable        = 1'b1;
      pin_typed          = 1'b0;
      pin_force          = '0;
      pin_sat            = 1'b0;
      smp                = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table. From reset, level 0 saturates the model and the default
      // half weight gives half of full-scale force.
      directed_rows.push_back(pinned_row(0, 40'sh3F_FFFF_FFFF, 1'b1));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(512));
      directed_rows.push_back(write_row(CSR_SPARE, '1));
      // unity weights: the output is the model force itself
      directed_rows.push_back(write_row(CSR_LEVEL_GAIN, CSR_DATA_W'(GAIN_ONE)));
      directed_rows.push_back(write_row(CSR_FORCE_GAIN, CSR_DATA_W'(GAIN_ONE)));
      directed_rows.push_back(pinned_row(0, FORCE_MAX, 1'b1));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(1));
      // one ohm at level 1 overflows the model: clamped
      directed_rows.push_back(write_row(CSR_SERIES_RES, CSR_DATA_W'(1)));
      directed_rows.push_back(pinned_row(1, FORCE_MAX, 1'b1));
      // zero resistor behaves like a zero level
      directed_rows.push_back(write_row(CSR_SERIES_RES, '0));
      directed_rows.push_back(pinned_row(700, FORCE_MAX, 1'b1));
      directed_rows.push_back(write_row(CSR_SERIES_RES, '1));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(2));
      // prediction only: extrapolate from the last two forces, no model weight
      directed_rows.push_back(write_row(CSR_FORCE_GAIN, '0));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(1023));
      // gains above unity (upper data bits set too) act as unity
      directed_rows.push_back(write_row(CSR_LEVEL_GAIN, '1));
      directed_rows.push_back(write_row(CSR_FORCE_GAIN, '1));
      directed_rows.push_back(pinned_row(0, FORCE_MAX, 1'b1));
      directed_rows.push_back(sample_row(1023));
      // steep fall from full force, then prediction only: runs to the low clamp
      directed_rows.push_back(write_row(CSR_FORCE_GAIN, '0));
      directed_rows.push_back(sample_row(300));
      directed_rows.push_back(sample_row(300));
      directed_rows.push_back(sample_row(300));
      // zero level gain freezes the level; tiny force weight
      directed_rows.push_back(write_row(CSR_LEVEL_GAIN, '0));
      directed_rows.push_back(write_row(CSR_FORCE_GAIN, CSR_DATA_W'(1)));
      directed_rows.push_back(sample_row(1023));
      directed_rows.push_back(sample_row(0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_csr(directed_rows[i].index, directed_rows[i].value);
         end else begin
            pin_typed = directed_rows[i].pinned;
            pin_force = directed_rows[i].want_force;
            pin_sat   = directed_rows[i].want_sat;
            send_sample(directed_rows[i].value[SAMPLE_BITS-1:0]);
         end
      end
      pin_typed = 1'b0;

      // Random phases: drain, new setting, a run of samples. Some phases and
      // the whole tail run with no idling on either side.
      sent = 0;
      while (sent < ITEM_TARGET) begin
         drain_results();
         idle_enable = (sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
         write_csr(CSR_LEVEL_GAIN, pick_gain());
         write_csr(CSR_FORCE_GAIN, pick_gain());
         write_csr(CSR_SERIES_RES, pick_resistance());
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_SPARE, CSR_DATA_W'($urandom()));
         phase_len = $urandom_range(10, 80);
         repeat (phase_len) begin
            // extremes, held values (steady level), and plain random samples
            case ($urandom_range(0, 9))
               0:       smp = '0;
               1:       smp = '1;
               2, 3:    ;
               default: smp = SAMPLE_BITS'($urandom_range(0, 1023));
            endcase
            send_sample(smp);
            sent++;
         end
      end

      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_fsr_force_predictive_filter passed");
      end else begin
         $display("tb_fsr_force_predictive_filter failed");
      end
      $finish;
   end

endmodule

// ===== fsr_force_predictive_filter.f =====
+incdir+hw/rtl
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_req_if.sv
hw/rtl/fsr_rsp_if.sv
hw/rtl/fsr_serial_mul.sv
hw/rtl/fsr_serial_div.sv
hw/rtl/fsr_force_predictive_filter.sv
bench/tb_fsr_force_predictive_filter.sv
